// ===== hdl/srrw_pkg.sv =====
// Shared types and constants for the selective-repeat receive window.
// Used by srrw_cell, srrw_cell_row and selective_repeat_receive_window.
// No dependencies.
package srrw_pkg;

  // Field widths
  localparam int SEQ_W    = 31;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 11;
  localparam int SLOT_W   = 7;
  localparam int BYTES_W  = 17;

  // Geometry
  localparam int WINDOW_SIZE_DEF = 16;
  localparam int BUFFER_SLOTS    = 64;
  localparam int PAYLOAD_BYTES   = 1024;

  // Saturation limits
  localparam logic [SLOT_W-1:0]  SLOT_MAX    = '1;
  localparam logic [BYTES_W-1:0] BYTES_MAX   = '1;
  localparam logic [BYTES_W-1:0] BATCH_LIMIT = BYTES_W'(BUFFER_SLOTS * PAYLOAD_BYTES);
  localparam logic [SLOT_W-1:0]  SLOT_LAST   = SLOT_W'(BUFFER_SLOTS - 1);
  localparam logic [LEN_W-1:0]   LEN_MAX     = LEN_W'(PAYLOAD_BYTES);

  // Packet status codes
  localparam logic [STATUS_W-1:0] STATUS_GOOD    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CORRUPT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FINAL   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EVAL,
    ST_SLIDE
  } state_t;

  // Commands broadcast to every cell
  typedef struct packed {
    logic              restart;
    logic              mark;
    logic              shift;
    logic [SLOT_W-1:0] fill_slot;
  } cell_ctrl_t;

  // What the row reports back
  typedef struct packed {
    logic              head_received;
    logic [SLOT_W-1:0] read_slot;
  } row_status_t;

endpackage

// ===== hdl/srrw_cell.sv =====
// One window entry: received flag and buffer slot.
// Loads from its upper neighbor on a shift. Depends on srrw_pkg.
module srrw_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  srrw_pkg::cell_ctrl_t      ctrl,
  input  logic [srrw_pkg::SLOT_W-1:0] init_slot,
  input  logic                      hit,
  input  logic                      in_received,
  input  logic [srrw_pkg::SLOT_W-1:0] in_slot,
  output logic                      received,
  output logic [srrw_pkg::SLOT_W-1:0] slot
);
  import srrw_pkg::*;

  // Restart, shift from neighbor, or mark on a lookup hit
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      received <= 1'b0;
      slot     <= init_slot;
    end else if (ctrl.shift) begin
      received <= in_received;
      slot     <= in_slot;
    end else if (ctrl.mark && hit) begin
      received <= 1'b1;
    end
  end

endmodule

// ===== hdl/srrw_cell_row.sv =====
// Row of window cells, lowest sequence number at index 0.
// Fresh slots enter at the tail on a shift. Depends on srrw_pkg, srrw_cell.
module srrw_cell_row #(
  parameter int WINDOW_SIZE = srrw_pkg::WINDOW_SIZE_DEF,
  parameter int IDX_W       = $clog2(WINDOW_SIZE)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  srrw_pkg::cell_ctrl_t  ctrl,
  input  logic [IDX_W-1:0]      idx,
  output srrw_pkg::row_status_t status
);
  import srrw_pkg::*;

  logic                  recv [WINDOW_SIZE];
  logic [SLOT_W-1:0]     slot [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] hit;

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    logic              nb_received;
    logic [SLOT_W-1:0] nb_slot;

    assign hit[i] = (idx == IDX_W'(i));

    // Tail takes the fresh slot; others take their upper neighbor
    if (i == WINDOW_SIZE - 1) begin : g_tail
      assign nb_received = 1'b0;
      assign nb_slot     = ctrl.fill_slot;
    end else begin : g_body
      assign nb_received = recv[i+1];
      assign nb_slot     = slot[i+1];
    end

    srrw_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .init_slot   (SLOT_W'(i)),
      .hit         (hit[i]),
      .in_received (nb_received),
      .in_slot     (nb_slot),
      .received    (recv[i]),
      .slot        (slot[i])
    );
  end

  // One-hot select of the addressed slot
  always_comb begin
    status.head_received = recv[0];
    status.read_slot     = '0;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      status.read_slot = status.read_slot | (hit[i] ? slot[i] : '0);
    end
  end

endmodule

// ===== hdl/selective_repeat_receive_window.sv =====
// Selective-repeat ARQ receive window, top level.
// Holds the sequencer, window base, slot and byte counters and the output
// register. Depends on srrw_pkg and srrw_cell_row.
//
// Input channel (s_*): one decoded packet per request, sequence number and
// length in s_tdata, status in s_tuser. Output channel (m_*): at most one
// result per packet: ack, write request and flush information.
// s_tready is high only while the sequencer is idle, so one packet is in
// work at a time. Steps from one accepted packet to the next:
//   in-window, no flush: check, evaluate, then slide out the k received
//     entries (k = 0..WINDOW_SIZE), one cell-row shift per cycle;
//   in-window with flush, or below the window: check, then evaluate;
//   above the window or after the final packet: check only (no result).
// A packet is captured on acceptance, then checked, and its result enters the output register from the evaluate step.
// If the register still holds a result, with m_tready low, while a new result is due,
// the sequencer waits in its evaluate step until the register frees up; the next
// packet is still taken while an earlier result waits to be read.
// Reset (rst, synchronous) clears the window to base 0, slots 0..W-1, empty
// batch and no transfer finished; no clearing pass is needed.
module selective_repeat_receive_window #(
  parameter int WINDOW_SIZE = srrw_pkg::WINDOW_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // packet_seq[30:0], payload_length[41:31], zero fill
  input  logic [1:0]  s_tuser,   // packet_status[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // ack_seq[30:0], write_slot[37:31], write_length[48:38],
                                 // flush_bytes[65:49], zero fill
  output logic [3:0]  m_tuser,   // ack_error[0], write_valid[1], slot_overflow[2], flush[3]
  output logic        m_tlast    // finished
);
  import srrw_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_SIZE);

  state_t state, state_next;

  // Captured request
  logic [SEQ_W-1:0]    seq;
  logic [STATUS_W-1:0] status;
  logic [LEN_W-1:0]    len;

  // Lookup results
  logic             below, inwin;
  logic [IDX_W-1:0] idx;

  // Window state
  logic [SEQ_W-1:0]   window_base;
  logic [SLOT_W-1:0]  next_slot;
  logic [BYTES_W-1:0] batch_bytes;
  logic               transfer_done;

  // Output register
  logic               out_valid;
  logic [SEQ_W-1:0]   out_ack_seq;
  logic               out_ack_error;
  logic               out_write_valid;
  logic [SLOT_W-1:0]  out_write_slot;
  logic [LEN_W-1:0]   out_write_length;
  logic               out_overflow;
  logic               out_flush;
  logic [BYTES_W-1:0] out_flush_bytes;
  logic               out_finished;

  cell_ctrl_t  ctrl;
  row_status_t row;

  // Combinational helpers
  logic               err, fin, out_free, load_out, flush_now;
  logic [SEQ_W-1:0]   offset;
  logic [LEN_W-1:0]   len_clamped;
  logic [BYTES_W:0]   bytes_sum;
  logic [BYTES_W-1:0] bytes_sat;

  assign err         = (status == STATUS_CORRUPT) || (status == STATUS_INVALID);
  assign fin         = (status == STATUS_FINAL);
  assign offset      = seq - window_base;
  assign len_clamped = (s_tdata[41:31] > LEN_MAX) ? LEN_MAX : s_tdata[41:31];
  assign bytes_sum   = {1'b0, batch_bytes} + (BYTES_W+1)'(len);
  assign bytes_sat   = bytes_sum[BYTES_W] ? BYTES_MAX : bytes_sum[BYTES_W-1:0];
  assign flush_now   = fin || (bytes_sat >= BATCH_LIMIT);
  assign out_free    = !out_valid || m_tready;

  srrw_cell_row #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .IDX_W       (IDX_W)
  ) u_row (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .idx    (idx),
    .status (row)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and cell commands
  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    load_out       = 1'b0;
    ctrl.restart   = 1'b0;
    ctrl.mark      = 1'b0;
    ctrl.shift     = 1'b0;
    ctrl.fill_slot = next_slot;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (transfer_done) begin
          state_next = ST_IDLE;
        end else if (seq < window_base || offset < SEQ_W'(WINDOW_SIZE)) begin
          state_next = ST_EVAL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          load_out = 1'b1;
          if (below || !inwin) begin
            state_next = ST_IDLE;
          end else begin
            ctrl.mark = !err;
            if (flush_now) begin
              ctrl.restart = 1'b1;
              state_next   = ST_IDLE;
            end else begin
              state_next = ST_SLIDE;
            end
          end
        end
      end
      ST_SLIDE: begin
        if (row.head_received) begin
          ctrl.shift = 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Request capture and lookup registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      seq    <= s_tdata[30:0];
      status <= s_tuser;
      len    <= len_clamped;
    end
    if (state == ST_CHECK) begin
      below <= seq < window_base;
      inwin <= !(seq < window_base) && (offset < SEQ_W'(WINDOW_SIZE));
      idx   <= offset[IDX_W-1:0];
    end
  end

  // Window base, slot counter, batch bytes, done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      window_base   <= '0;
      next_slot     <= SLOT_W'(WINDOW_SIZE);
      batch_bytes   <= '0;
      transfer_done <= 1'b0;
    end else if (ctrl.restart) begin
      window_base   <= window_base + SEQ_W'(WINDOW_SIZE);
      next_slot     <= SLOT_W'(WINDOW_SIZE);
      batch_bytes   <= '0;
      transfer_done <= fin;
    end else begin
      if (ctrl.mark || (load_out && inwin && !below)) begin
        batch_bytes <= bytes_sat;
      end
      if (ctrl.shift) begin
        window_base <= window_base + SEQ_W'(1);
        if (next_slot != SLOT_MAX) begin
          next_slot <= next_slot + SLOT_W'(1);
        end
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ack_seq   <= seq;
      out_ack_error <= err;
      if (below) begin
        out_write_valid  <= 1'b0;
        out_write_slot   <= '0;
        out_write_length <= '0;
        out_overflow     <= 1'b0;
        out_flush        <= 1'b0;
        out_flush_bytes  <= '0;
        out_finished     <= 1'b0;
      end else begin
        out_write_valid  <= 1'b1;
        out_overflow     <= row.read_slot >= SLOT_W'(BUFFER_SLOTS);
        out_write_slot   <= (row.read_slot >= SLOT_W'(BUFFER_SLOTS)) ? SLOT_LAST
                                                                     : row.read_slot;
        out_write_length <= len;
        out_flush        <= flush_now;
        out_flush_bytes  <= flush_now ? bytes_sat : '0;
        out_finished     <= fin;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_flush_bytes, out_write_length, out_write_slot, out_ack_seq};
  assign m_tuser  = {out_flush, out_overflow, out_write_valid, out_ack_error};
  assign m_tlast  = out_finished;

  // Finished only comes with a flush
  a_finish_flush: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_finished |-> out_flush)
    else $error("finished without flush");

  // Byte count shown only on a flush
  a_bytes_flush: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_flush |-> out_flush_bytes == '0)
    else $error("flush_bytes without flush");

  // Overflow only on a write
  a_ovf_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_overflow |-> out_write_valid)
    else $error("slot overflow without write");

  // Transfer stays finished until reset
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    transfer_done |=> transfer_done)
    else $error("transfer_done cleared");

  // Each slide step moves the base by one
  a_slide_base: assert property (@(posedge clk) disable iff (rst)
    state == ST_SLIDE && row.head_received |=>
      window_base == $past(window_base) + SEQ_W'(1))
    else $error("window base slide mismatch");

endmodule
